FILE: hw/rtl/pgbc_pkg.sv
// ----------------------------------------------------------------------------
// pgbc_pkg
// Shared types and constants of the pixel gray and bitmap converter.
// ----------------------------------------------------------------------------
package pgbc_pkg;

  // Largest row or column count taken from the dimension registers
  localparam logic [11:0] MaxDimension = 12'd4095;

  // Configuration register indexes
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 12;
  localparam logic [CfgIndexWidth-1:0] RegMode        = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegMaxValue    = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegImageWidth  = 2'd2;
  localparam logic [CfgIndexWidth-1:0] RegImageHeight = 2'd3;

  // Mode codes
  localparam logic ModeGray   = 1'b0;
  localparam logic ModeBitmap = 1'b1;

  // Depth of the queue between the front and the back
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);

  // Gray weights and the divide-by-1000 reciprocal (2^20 / 1000, rounded down)
  localparam int unsigned SumWidth   = 18;
  localparam logic [SumWidth-1:0] WeightRed   = 18'd299;
  localparam logic [SumWidth-1:0] WeightGreen = 18'd587;
  localparam logic [SumWidth-1:0] WeightBlue  = 18'd114;
  localparam logic [SumWidth-1:0] Divisor     = 18'd1000;
  localparam int unsigned RecipShift = 20;
  localparam int unsigned ProdWidth  = SumWidth + 11;
  localparam logic [ProdWidth-1:0] RecipMul = 29'd1048;

  // Kind of work handed from the front to the back
  typedef enum logic [1:0] {
    JobGray  = 2'd0,
    JobBits  = 2'd1,
    JobError = 2'd2
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] red;    // packed byte for bitmap items
    logic [7:0] green;
    logic [7:0] blue;
    logic       eoi;
  } job_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  max_value;
    logic [11:0] image_width;
    logic [11:0] image_height;
  } cfg_t;

endpackage

FILE: hw/rtl/pgbc_front.sv
// ----------------------------------------------------------------------------
// pgbc_front
// Takes sample bytes, range-checks them, gathers colour components or packs
// bitmap bits, tracks row and column, and issues jobs to the queue.
// ----------------------------------------------------------------------------
module pgbc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pgbc_pkg::cfg_t    cfg_i,
  input  logic              accept_i,
  input  logic [7:0]        pixel_byte_i,
  output logic              push_o,
  output pgbc_pkg::job_t    job_o
);

  logic [1:0]  chan_q, chan_d;
  logic [7:0]  red_q, red_d;
  logic [7:0]  green_q, green_d;
  logic [7:0]  shift_q, shift_d;
  logic [2:0]  bcnt_q, bcnt_d;
  logic [11:0] col_q, col_d;
  logic [11:0] row_q, row_d;
  logic        err_q, err_d;

  logic [11:0] width_eff, height_eff;
  logic        row_end, img_end;
  logic [11:0] col_adv, row_adv;
  logic [8:0]  thr_wide;
  logic [7:0]  thr;
  logic        bit_val;
  logic [7:0]  shift_new;
  logic [3:0]  filled;
  logic [2:0]  pad;
  logic [7:0]  packed_byte;

  // Dimension clamping: zero counts as one, cap at the maximum
  always_comb begin
    width_eff  = (cfg_i.image_width == 12'd0) ? 12'd1 : cfg_i.image_width;
    height_eff = (cfg_i.image_height == 12'd0) ? 12'd1 : cfg_i.image_height;
    if (width_eff > pgbc_pkg::MaxDimension) width_eff = pgbc_pkg::MaxDimension;
    if (height_eff > pgbc_pkg::MaxDimension) height_eff = pgbc_pkg::MaxDimension;
  end

  // Next pixel position
  assign row_end = ({1'b0, col_q} + 13'd1) >= {1'b0, width_eff};
  assign img_end = row_end && (({1'b0, row_q} + 13'd1) >= {1'b0, height_eff});
  assign col_adv = row_end ? 12'd0 : col_q + 12'd1;
  assign row_adv = !row_end ? row_q : (img_end ? 12'd0 : row_q + 12'd1);

  // Bitmap threshold and packing with one-bit padding at row end
  assign thr_wide    = ({1'b0, cfg_i.max_value} + 9'd1) >> 1;
  assign thr         = thr_wide[7:0];
  assign bit_val     = !(pixel_byte_i > thr);
  assign shift_new   = {shift_q[6:0], bit_val};
  assign filled      = {1'b0, bcnt_q} + 4'd1;
  assign pad         = 3'(4'd8 - filled);
  assign packed_byte = (shift_new << pad) | ~(8'hFF << pad);

  // Per-item state update and job issue
  always_comb begin
    chan_d  = chan_q;
    red_d   = red_q;
    green_d = green_q;
    shift_d = shift_q;
    bcnt_d  = bcnt_q;
    col_d   = col_q;
    row_d   = row_q;
    err_d   = err_q;
    push_o  = 1'b0;
    job_o   = '{kind: pgbc_pkg::JobGray, red: red_q, green: green_q,
                blue: pixel_byte_i, eoi: img_end};
    if (accept_i && !err_q) begin
      if (pixel_byte_i > cfg_i.max_value) begin
        err_d     = 1'b1;
        push_o    = 1'b1;
        job_o     = '{kind: pgbc_pkg::JobError, red: 8'd0, green: 8'd0,
                      blue: 8'd0, eoi: 1'b0};
      end else if (cfg_i.mode == pgbc_pkg::ModeGray) begin
        case (chan_q)
          2'd0: begin
            red_d  = pixel_byte_i;
            chan_d = 2'd1;
          end
          2'd1: begin
            green_d = pixel_byte_i;
            chan_d  = 2'd2;
          end
          default: begin
            chan_d = 2'd0;
            push_o = 1'b1;
            col_d  = col_adv;
            row_d  = row_adv;
          end
        endcase
      end else begin
        col_d = col_adv;
        row_d = row_adv;
        if (filled < 4'd8 && !row_end) begin
          shift_d = shift_new;
          bcnt_d  = filled[2:0];
        end else begin
          shift_d = 8'd0;
          bcnt_d  = 3'd0;
          push_o  = 1'b1;
          job_o   = '{kind: pgbc_pkg::JobBits, red: packed_byte, green: 8'd0,
                      blue: 8'd0, eoi: img_end};
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q  <= 2'd0;
      red_q   <= 8'd0;
      green_q <= 8'd0;
      shift_q <= 8'd0;
      bcnt_q  <= 3'd0;
      col_q   <= 12'd0;
      row_q   <= 12'd0;
      err_q   <= 1'b0;
    end else begin
      chan_q  <= chan_d;
      red_q   <= red_d;
      green_q <= green_d;
      shift_q <= shift_d;
      bcnt_q  <= bcnt_d;
      col_q   <= col_d;
      row_q   <= row_d;
      err_q   <= err_d;
    end
  end

endmodule

FILE: hw/rtl/pgbc_queue.sv
// ----------------------------------------------------------------------------
// pgbc_queue
// Short job queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module pgbc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pgbc_pkg::job_t job_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output pgbc_pkg::job_t job_o
);

  localparam int unsigned PtrW = pgbc_pkg::QueuePtrWidth;

  pgbc_pkg::job_t      mem_q [pgbc_pkg::QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]       count_q;
  logic                do_push, do_pop;

  assign full_o  = count_q == (PtrW+1)'(pgbc_pkg::QueueDepth);
  assign valid_o = count_q != '0;
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= job_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= PtrW'(wr_ptr_q + 1'b1);
      if (do_pop)  rd_ptr_q <= PtrW'(rd_ptr_q + 1'b1);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: hw/rtl/pgbc_back.sv
// ----------------------------------------------------------------------------
// pgbc_back
// Three-stage gray pipeline: weighted sum, reciprocal estimate, correction
// into the output register. Bitmap and error items ride along unchanged.
// ----------------------------------------------------------------------------
module pgbc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  pgbc_pkg::job_t job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           range_error_o,
  output logic           end_of_image_o
);

  localparam int unsigned SW = pgbc_pkg::SumWidth;
  localparam int unsigned PW = pgbc_pkg::ProdWidth;

  logic                  adv;
  logic                  v1_q, v2_q, vo_q;
  pgbc_pkg::job_kind_e   kind1_q, kind2_q;
  logic [7:0]            byte1_q, byte2_q;
  logic                  eoi1_q, eoi2_q;
  logic [SW-1:0]         sum_d, sum1_q, sum2_q;
  logic [PW-1:0]         prod;
  logic [7:0]            est2_q;
  logic [SW-1:0]         rem;
  logic [7:0]            gray;
  logic [7:0]            byte_q;
  logic                  err_q, eoi_q;

  // Whole pipe moves when the output register is free or being taken
  assign adv   = !vo_q || !out_stall_i;
  assign pop_o = adv && job_valid_i;

  // Stage 1: weighted sum
  assign sum_d = pgbc_pkg::WeightRed   * SW'(job_i.red)
               + pgbc_pkg::WeightGreen * SW'(job_i.green)
               + pgbc_pkg::WeightBlue  * SW'(job_i.blue);

  // Stage 2: quotient estimate, at most one below the true value
  assign prod = PW'(sum1_q) * pgbc_pkg::RecipMul;

  // Stage 3: one compare and correct
  assign rem  = sum2_q - SW'(SW'(est2_q) * pgbc_pkg::Divisor);
  assign gray = (rem >= pgbc_pkg::Divisor) ? est2_q + 8'd1 : est2_q;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= pop_o;
      v2_q <= v1_q;
      vo_q <= v2_q;
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind1_q <= job_i.kind;
      byte1_q <= job_i.red;
      eoi1_q  <= job_i.eoi;
      sum1_q  <= sum_d;
      kind2_q <= kind1_q;
      byte2_q <= byte1_q;
      eoi2_q  <= eoi1_q;
      sum2_q  <= sum1_q;
      est2_q  <= prod[pgbc_pkg::RecipShift +: 8];
      eoi_q   <= eoi2_q;
      case (kind2_q)
        pgbc_pkg::JobGray: begin
          byte_q <= gray;
          err_q  <= 1'b0;
        end
        pgbc_pkg::JobError: begin
          byte_q <= 8'd0;
          err_q  <= 1'b1;
        end
        default: begin
          byte_q <= byte2_q;
          err_q  <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o    = vo_q;
  assign out_byte_o     = byte_q;
  assign range_error_o  = err_q;
  assign end_of_image_o = eoi_q;

endmodule

FILE: hw/rtl/pixel_gray_and_bitmap_converter.sv
// ----------------------------------------------------------------------------
// pixel_gray_and_bitmap_converter
// Raw pixel-data converter: colour to gray bytes, or gray to packed bitmap.
//
//   channel   direction  handshake             payload
//   input     in         in_valid_i/in_stall_o pixel_byte_i
//   output    out        out_valid_o/out_stall_i out_byte_o, range_error_o,
//                                              end_of_image_o
//   config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the output is not stalled. A result
// reaches the output register via the queue, sum stage and estimate stage.
// Input stalls only while the four-entry job queue is full; the back pipe
// holds as a whole while the output is stalled. Reset clears all counters,
// the error latch and the configuration to its defaults; no clearing pass.
// ----------------------------------------------------------------------------
module pixel_gray_and_bitmap_converter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          pixel_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [7:0]                          out_byte_o,
  output logic                                range_error_o,
  output logic                                end_of_image_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pgbc_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [pgbc_pkg::CfgDataWidth-1:0]   cfg_data_i
);

  pgbc_pkg::cfg_t cfg_q;
  pgbc_pkg::job_t push_job, pop_job;
  logic           accept, push, full, job_valid, pop;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: pgbc_pkg::ModeGray, max_value: 8'd255,
                 image_width: 12'd1, image_height: 12'd1};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pgbc_pkg::RegMode:        cfg_q.mode         <= cfg_data_i[0];
        pgbc_pkg::RegMaxValue:    cfg_q.max_value    <= cfg_data_i[7:0];
        pgbc_pkg::RegImageWidth:  cfg_q.image_width  <= cfg_data_i[11:0];
        pgbc_pkg::RegImageHeight: cfg_q.image_height <= cfg_data_i[11:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  pgbc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .pixel_byte_i (pixel_byte_i),
    .push_o       (push),
    .job_o        (push_job)
  );

  pgbc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .valid_o (job_valid),
    .pop_i   (pop),
    .job_o   (pop_job)
  );

  pgbc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_i          (pop_job),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .range_error_o  (range_error_o),
    .end_of_image_o (end_of_image_o)
  );

endmodule

FILE: hw/rtl/pgbc_checker.sv
// ----------------------------------------------------------------------------
// pgbc_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module pgbc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       range_error_o,
  input logic       end_of_image_o
);

  // An error item carries a zero byte and never closes an image
  a_error_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |-> (out_byte_o == 8'd0 && !end_of_image_o))
    else $error("error item with non-zero byte or end flag");

  // Nothing follows an error item: the latch drops all later bytes
  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && range_error_o) |=> !out_valid_o)
    else $error("item delivered after a range error");

  // A stalled item holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_byte_o) && $stable(range_error_o)
       && $stable(end_of_image_o)))
    else $error("stalled output item changed");

endmodule

bind pixel_gray_and_bitmap_converter pgbc_checker u_pgbc_checker (.*);
